/* hw/rtl/integer_alu_power_root_assert.svh */
// Assertion macros used by the checker file of integer_alu_power_root.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef INTEGER_ALU_POWER_ROOT_ASSERT_SVH
`define INTEGER_ALU_POWER_ROOT_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define IAPR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define IAPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/iapr_pkg.sv */
// Package for integer_alu_power_root: beat structs, codes, controller states,
// and the command/status structs between controller and datapath. No dependencies.
package iapr_pkg;

    // multiplier digit width: one W x MUL_DIGIT partial product per cycle
    localparam int MUL_DIGIT = 16;

    typedef enum logic [2:0] {
        ACT_ADD    = 3'd0,
        ACT_SUB    = 3'd1,
        ACT_MUL    = 3'd2,
        ACT_DIV    = 3'd3,
        ACT_REM    = 3'd4,
        ACT_POW    = 3'd5,
        ACT_SQRT   = 3'd6,
        ACT_UNUSED = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DIV0     = 3'd1,
        ST_NEG_ROOT = 3'd2,
        ST_NEG_EXP  = 3'd3,
        ST_BAD_ACT  = 3'd4
    } t_status;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [31:0] result;
        logic [2:0]         status;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV_RUN,
        S_SQRT_RUN,
        S_POW_TEST,
        S_POW_SQ,
        S_MUL_LOAD,
        S_MUL_RUN,
        S_MUL_WB,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADD,
        OP_SUB,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_POW_INIT,
        OP_MUL_LOAD,
        OP_MUL_STEP,
        OP_MUL_WB,
        OP_FINISH
    } t_dp_op;

    // which operands feed the multiplier and where the product goes
    typedef enum logic [1:0] {
        MK_AB,   // a * b into acc
        MK_ACC,  // acc * base into acc
        MK_SQ    // base * base into base, exponent shifts
    } t_mul_kind;

    typedef enum logic [1:0] {
        RS_ZERO,
        RS_ACC,
        RS_QUOT,
        RS_REM
    } t_res_sel;

    typedef struct packed {
        t_dp_op    op;
        t_mul_kind mul_kind;
        t_res_sel  res_sel;
        t_status   status;
    } t_dp_cmd;

    typedef struct packed {
        logic a_neg;
        logic b_neg;
        logic b_zero;
        logic b_lsb;
        logic b_one;      // b >> 1 is zero
        logic sqrt_last;  // root bit at its last position
    } t_dp_stat;

endpackage

/* hw/rtl/iapr_ctrl.sv */
// Controller FSM for integer_alu_power_root: sequences the datapath steps.
// Depends on iapr_pkg.
module iapr_ctrl #(
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [2:0]         i_action,
    input  iapr_pkg::t_dp_stat i_stat,
    output iapr_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    localparam int NDIG = (DATA_WIDTH + iapr_pkg::MUL_DIGIT - 1) / iapr_pkg::MUL_DIGIT;
    localparam int CW   = $clog2(DATA_WIDTH);

    iapr_pkg::t_state    r_state,  n_state;
    iapr_pkg::t_action   r_act,    n_act;
    iapr_pkg::t_mul_kind r_kind,   n_kind;
    iapr_pkg::t_status   r_status, n_status;
    iapr_pkg::t_res_sel  r_sel,    n_sel;
    logic [CW-1:0]       r_cnt,    n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= iapr_pkg::S_IDLE;
            r_act    <= iapr_pkg::ACT_ADD;
            r_kind   <= iapr_pkg::MK_AB;
            r_status <= iapr_pkg::ST_OK;
            r_sel    <= iapr_pkg::RS_ZERO;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_act    <= n_act;
            r_kind   <= n_kind;
            r_status <= n_status;
            r_sel    <= n_sel;
            r_cnt    <= n_cnt;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_act            = r_act;
        n_kind           = r_kind;
        n_status         = r_status;
        n_sel            = r_sel;
        n_cnt            = r_cnt;
        o_cmd.op         = iapr_pkg::OP_NONE;
        o_cmd.mul_kind   = r_kind;
        o_cmd.res_sel    = r_sel;
        o_cmd.status     = r_status;

        case (r_state)
            iapr_pkg::S_IDLE: begin
                if (i_start) begin
                    n_act    = iapr_pkg::t_action'(i_action);
                    o_cmd.op = iapr_pkg::OP_LOAD;
                    n_state  = iapr_pkg::S_CHECK;
                end
            end
            iapr_pkg::S_CHECK: begin
                n_status = iapr_pkg::ST_OK;
                n_sel    = iapr_pkg::RS_ACC;
                n_cnt    = '0;
                case (r_act)
                    iapr_pkg::ACT_ADD: begin
                        o_cmd.op = iapr_pkg::OP_ADD;
                        n_state  = iapr_pkg::S_DONE;
                    end
                    iapr_pkg::ACT_SUB: begin
                        o_cmd.op = iapr_pkg::OP_SUB;
                        n_state  = iapr_pkg::S_DONE;
                    end
                    iapr_pkg::ACT_MUL: begin
                        n_kind  = iapr_pkg::MK_AB;
                        n_state = iapr_pkg::S_MUL_LOAD;
                    end
                    iapr_pkg::ACT_DIV, iapr_pkg::ACT_REM: begin
                        if (i_stat.b_zero) begin
                            n_status = iapr_pkg::ST_DIV0;
                            n_sel    = iapr_pkg::RS_ZERO;
                            n_state  = iapr_pkg::S_DONE;
                        end else begin
                            o_cmd.op = iapr_pkg::OP_DIV_INIT;
                            n_sel    = (r_act == iapr_pkg::ACT_DIV) ? iapr_pkg::RS_QUOT
                                                                    : iapr_pkg::RS_REM;
                            n_state  = iapr_pkg::S_DIV_RUN;
                        end
                    end
                    iapr_pkg::ACT_POW: begin
                        if (i_stat.b_neg) begin
                            n_status = iapr_pkg::ST_NEG_EXP;
                            n_sel    = iapr_pkg::RS_ZERO;
                            n_state  = iapr_pkg::S_DONE;
                        end else begin
                            o_cmd.op = iapr_pkg::OP_POW_INIT;
                            n_state  = iapr_pkg::S_POW_TEST;
                        end
                    end
                    iapr_pkg::ACT_SQRT: begin
                        if (i_stat.a_neg) begin
                            n_status = iapr_pkg::ST_NEG_ROOT;
                            n_sel    = iapr_pkg::RS_ZERO;
                            n_state  = iapr_pkg::S_DONE;
                        end else begin
                            o_cmd.op = iapr_pkg::OP_SQRT_INIT;
                            n_state  = iapr_pkg::S_SQRT_RUN;
                        end
                    end
                    default: begin
                        n_status = iapr_pkg::ST_BAD_ACT;
                        n_sel    = iapr_pkg::RS_ZERO;
                        n_state  = iapr_pkg::S_DONE;
                    end
                endcase
            end
            iapr_pkg::S_DIV_RUN: begin
                o_cmd.op = iapr_pkg::OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CW'(DATA_WIDTH - 1)) begin
                    n_state = iapr_pkg::S_DONE;
                end
            end
            iapr_pkg::S_SQRT_RUN: begin
                o_cmd.op = iapr_pkg::OP_SQRT_STEP;
                if (i_stat.sqrt_last) begin
                    n_state = iapr_pkg::S_DONE;
                end
            end
            iapr_pkg::S_POW_TEST: begin
                if (i_stat.b_zero) begin
                    n_state = iapr_pkg::S_DONE;
                end else if (i_stat.b_lsb) begin
                    n_kind  = iapr_pkg::MK_ACC;
                    n_state = iapr_pkg::S_MUL_LOAD;
                end else begin
                    n_kind  = iapr_pkg::MK_SQ;
                    n_state = iapr_pkg::S_MUL_LOAD;
                end
            end
            iapr_pkg::S_POW_SQ: begin
                // last exponent bit used: skip the final squaring
                if (i_stat.b_one) begin
                    n_state = iapr_pkg::S_DONE;
                end else begin
                    n_kind  = iapr_pkg::MK_SQ;
                    n_state = iapr_pkg::S_MUL_LOAD;
                end
            end
            iapr_pkg::S_MUL_LOAD: begin
                o_cmd.op = iapr_pkg::OP_MUL_LOAD;
                n_cnt    = '0;
                n_state  = iapr_pkg::S_MUL_RUN;
            end
            iapr_pkg::S_MUL_RUN: begin
                o_cmd.op = iapr_pkg::OP_MUL_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CW'(NDIG - 1)) begin
                    n_state = iapr_pkg::S_MUL_WB;
                end
            end
            iapr_pkg::S_MUL_WB: begin
                o_cmd.op = iapr_pkg::OP_MUL_WB;
                case (r_kind)
                    iapr_pkg::MK_ACC: n_state = iapr_pkg::S_POW_SQ;
                    iapr_pkg::MK_SQ:  n_state = iapr_pkg::S_POW_TEST;
                    default:          n_state = iapr_pkg::S_DONE;
                endcase
            end
            iapr_pkg::S_DONE: begin
                o_cmd.op = iapr_pkg::OP_FINISH;
                n_state  = iapr_pkg::S_IDLE;
            end
            default: begin
                n_state = iapr_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != iapr_pkg::S_IDLE);

endmodule

/* hw/rtl/iapr_dpath.sv */
// Datapath for integer_alu_power_root: operand registers, digit-serial multiplier,
// restoring divider and bit-pair root steps. Depends on iapr_pkg.
module iapr_dpath #(
    parameter int DATA_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iapr_pkg::t_in      i_in,
    input  iapr_pkg::t_dp_cmd  i_cmd,
    output iapr_pkg::t_dp_stat o_stat,
    output iapr_pkg::t_out     o_out,
    output logic               o_done
);

    localparam int W      = DATA_WIDTH;
    localparam int D      = iapr_pkg::MUL_DIGIT;
    localparam int NDIG   = (W + D - 1) / D;
    localparam int MPW    = NDIG * D;
    localparam int SQ_TOP = ((W - 2) / 2) * 2;

    logic [W-1:0]   r_a, r_b, r_acc, r_rem, r_bit, r_mc, r_prod;
    logic [MPW-1:0] r_mp;
    logic           r_neg_a, r_neg_b;
    iapr_pkg::t_out r_out;
    logic           r_done;

    logic [W-1:0]   w_a_in, w_b_in;
    logic [W+D-1:0] w_pp;
    logic [W-1:0]   w_rem_sh;
    logic [W:0]     w_diff;
    logic [W-1:0]   w_sq_t;
    logic           w_sq_ge;
    logic [W-1:0]   w_mul_mc, w_mul_mp;
    logic [W-1:0]   w_fix;

    always_comb begin
        w_a_in   = W'(i_in.operand_a);
        w_b_in   = W'(i_in.operand_b);
        w_pp     = (W+D)'(r_mc) * (W+D)'(r_mp[D-1:0]);
        w_rem_sh = {r_rem[W-2:0], r_a[W-1]};
        w_diff   = {1'b0, w_rem_sh} - {1'b0, r_b};
        w_sq_t   = r_acc + r_bit;
        w_sq_ge  = (r_a >= w_sq_t);

        case (i_cmd.mul_kind)
            iapr_pkg::MK_ACC: begin
                w_mul_mc = r_acc;
                w_mul_mp = r_a;
            end
            iapr_pkg::MK_SQ: begin
                w_mul_mc = r_a;
                w_mul_mp = r_a;
            end
            default: begin
                w_mul_mc = r_a;
                w_mul_mp = r_b;
            end
        endcase

        case (i_cmd.res_sel)
            iapr_pkg::RS_ACC:  w_fix = r_acc;
            iapr_pkg::RS_QUOT: w_fix = (r_neg_a ^ r_neg_b) ? (W'(0) - r_acc) : r_acc;
            iapr_pkg::RS_REM:  w_fix = r_neg_a ? (W'(0) - r_rem) : r_rem;
            default:           w_fix = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            iapr_pkg::OP_LOAD: begin
                r_a     <= w_a_in;
                r_b     <= w_b_in;
                r_neg_a <= w_a_in[W-1];
                r_neg_b <= w_b_in[W-1];
            end
            iapr_pkg::OP_ADD: r_acc <= r_a + r_b;
            iapr_pkg::OP_SUB: r_acc <= r_a - r_b;
            iapr_pkg::OP_DIV_INIT: begin
                r_a   <= r_neg_a ? (W'(0) - r_a) : r_a;
                r_b   <= r_neg_b ? (W'(0) - r_b) : r_b;
                r_rem <= '0;
                r_acc <= '0;
            end
            iapr_pkg::OP_DIV_STEP: begin
                r_a   <= r_a << 1;
                r_rem <= w_diff[W] ? w_rem_sh : w_diff[W-1:0];
                r_acc <= {r_acc[W-2:0], ~w_diff[W]};
            end
            iapr_pkg::OP_SQRT_INIT: begin
                r_acc <= '0;
                r_bit <= W'(1) << SQ_TOP;
            end
            iapr_pkg::OP_SQRT_STEP: begin
                if (w_sq_ge) begin
                    r_a   <= r_a - w_sq_t;
                    r_acc <= (r_acc >> 1) + r_bit;
                end else begin
                    r_acc <= r_acc >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            iapr_pkg::OP_POW_INIT: r_acc <= W'(1);
            iapr_pkg::OP_MUL_LOAD: begin
                r_mc   <= w_mul_mc;
                r_mp   <= MPW'(w_mul_mp);
                r_prod <= '0;
            end
            iapr_pkg::OP_MUL_STEP: begin
                r_prod <= r_prod + w_pp[W-1:0];
                r_mc   <= r_mc << D;
                r_mp   <= r_mp >> D;
            end
            iapr_pkg::OP_MUL_WB: begin
                if (i_cmd.mul_kind == iapr_pkg::MK_SQ) begin
                    r_a <= r_prod;
                    r_b <= r_b >> 1;
                end else begin
                    r_acc <= r_prod;
                end
            end
            iapr_pkg::OP_FINISH: begin
                r_out.result <= 32'(signed'(w_fix));
                r_out.status <= i_cmd.status;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (i_cmd.op == iapr_pkg::OP_FINISH);
        end
    end

    always_comb begin
        o_stat.a_neg     = r_neg_a;
        o_stat.b_neg     = r_neg_b;
        o_stat.b_zero    = (r_b == '0);
        o_stat.b_lsb     = r_b[0];
        o_stat.b_one     = ((r_b >> 1) == '0);
        o_stat.sqrt_last = |r_bit[1:0];
    end

    assign o_out  = r_out;
    assign o_done = r_done;

endmodule

/* hw/rtl/integer_alu_power_root.sv */
// Top level of the integer ALU with divide, power and square root.
// Depends on iapr_pkg, iapr_ctrl and iapr_dpath.
//
// Usage:
//   Input channel: drive i_in (action, operand_a, operand_b) and raise start.
//   The beat is taken on a rising edge with start high and busy low; busy then
//   stays high until the result has been formed.
//   Result channel: o_out (result, status) is valid for exactly one cycle,
//   marked by o_done. The receiver cannot stall; it must take the beat then.
//   busy is already low in the o_done cycle, so a new beat may be taken there.
// After the accept edge the controller passes a check state, the operation's
// steps and a done state. add, sub and the error cases need no steps; mul
// loads, runs and writes back the digit-serial multiplier (N = ceil(W/16) digits,
// W = DATA_WIDTH); div and remainder take one quotient bit per step; square root
// one root bit per step; power tests each exponent bit from the bottom, multiplies
// acc by base when it is set, and squares the base unless the top bit was just
// used; a zero exponent gives 1.
// One item at a time; the multiplier works in 16-bit digits, and the divide and
// root loops each produce one bit per cycle.
// Reset (synchronous, active low) returns the controller to idle and drops
// o_done; no memory needs clearing.
module integer_alu_power_root #(
    parameter int DATA_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  iapr_pkg::t_in  i_in,
    output iapr_pkg::t_out o_out,
    output logic           o_done
);

    iapr_pkg::t_dp_cmd  w_cmd;
    iapr_pkg::t_dp_stat w_stat;
    logic               w_accept;

    // beat accepted only while the controller is idle
    assign w_accept = start & ~busy;

    iapr_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_action (i_in.action),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    // datapath captures operands on the accept cycle (LOAD command)
    iapr_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_out   (o_out),
        .o_done  (o_done)
    );

endmodule

/* hw/rtl/iapr_chk.sv */
// Port-level checker for integer_alu_power_root, bound to the top level.
// Depends on iapr_pkg and integer_alu_power_root_assert.svh.
`include "integer_alu_power_root_assert.svh"

module iapr_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input iapr_pkg::t_out o_out,
    input logic           o_done
);

    // an accepted beat makes the block busy
    `IAPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")

    // a result only closes a busy period
    `IAPR_ASSERT_SAME(a_done_after_busy, o_done, $past(busy) && !busy, "result outside a busy period")

    // one result per item: the strobe is never held high
    `IAPR_ASSERT_NEXT(a_done_pulse, o_done, !o_done, "result strobe held")

    // errors always carry a zero result
    `IAPR_ASSERT_SAME(a_err_zero, o_done && (o_out.status != iapr_pkg::ST_OK), o_out.result == 0, "error with nonzero result")

endmodule

bind integer_alu_power_root iapr_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_out   (o_out),
    .o_done  (o_done)
);
